>>> hdl/hfas_pkg.sv
`default_nettype none

package hfas_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned EXP_W  = 5;
	localparam int unsigned MANT_W = 10;
	// magnitude after the add: at most two full significands, so 12 bits
	localparam int unsigned MAG_W  = MANT_W + 2;
	localparam int unsigned SHAMT_W = 4;
	localparam int unsigned LZ_W   = 4;
	// signed exponent after normalising: spans -10 .. 32
	localparam int unsigned NEXP_W = EXP_W + 2;

	localparam logic [WORD_W-1:0] SIGN_MASK = 16'h8000;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_SUB = 1'b1;

	typedef logic [WORD_W-1:0] half_t;

	// flip the sign, but leave the all-zero word alone
	function automatic half_t negate_half(input half_t x);
		half_t r;
		r = (x != '0) ? (x ^ SIGN_MASK) : x;
		return r;
	endfunction

	// hidden one plus mantissa, in two's complement by the sign bit
	function automatic half_t signed_sig(input half_t x);
		half_t m;
		m = {{(WORD_W-MANT_W-1){1'b0}}, 1'b1, x[MANT_W-1:0]};
		return x[WORD_W-1] ? half_t'(-m) : m;
	endfunction

endpackage

`default_nettype wire

>>> hdl/hfas_if.sv
`default_nettype none

interface hfas_op_if
	import hfas_pkg::*;
	();
	logic        valid;
	logic        ready;
	logic        command;
	half_t       operand_a;
	half_t       operand_b;

	modport source (output valid, command, operand_a, operand_b, input ready);
	modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface hfas_res_if
	import hfas_pkg::*;
	();
	logic        valid;
	logic        ready;
	half_t       result;
	logic        exponent_range_error;

	modport source (output valid, result, exponent_range_error, input ready);
	modport sink   (input valid, result, exponent_range_error, output ready);
endinterface

`default_nettype wire

>>> hdl/half_float_add_sub.sv
// One input register and one result register; asynchronous active-low reset
// empties both. An accepted operation is captured in the first and then moves
// to the second, where it is offered. Throughput: one operation per cycle
// while the result side does not stall; align, add and normalise sit in one
// combinational pass between the two registers. The input side keeps taking
// transfers while a result waits, until both registers hold an item.
`default_nettype none

module half_float_add_sub
	import hfas_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	hfas_op_if.sink    operation,
	hfas_res_if.source outcome
);

	logic              valid_s1;
	logic              cmd_s1;
	half_t             a_s1;
	half_t             b_s1;
	logic              valid_s2;
	half_t             result_s2;
	logic              err_s2;

	logic              take_in;
	logic              move_s1;

	half_t             y;
	logic              eq_sub;
	logic              cancel;
	logic [EXP_W-1:0]  ea;
	logic [EXP_W-1:0]  ey;
	logic              a_ge;
	logic [EXP_W-1:0]  diff;
	logic [SHAMT_W-1:0] shamt;
	logic [EXP_W-1:0]  common;
	half_t             xv;
	half_t             yv;
	half_t             xs;
	half_t             ys;
	half_t             sum;
	logic              sum_sign;
	half_t             mag16;
	logic [MAG_W-1:0]  mag;
	logic [LZ_W-1:0]   lz;
	logic [MANT_W:0]   norm;
	logic [MANT_W-1:0] mant;
	logic signed [NEXP_W-1:0] nexp;
	half_t             nxt_result;
	logic              nxt_err;

	assign move_s1         = valid_s1 && (!valid_s2 || outcome.ready);
	assign operation.ready = !valid_s1 || move_s1;
	assign take_in         = operation.valid && operation.ready;

	// align, add, normalise
	always_comb begin
		unique case (cmd_s1)
			CMD_ADD: y = b_s1;
			CMD_SUB: y = negate_half(b_s1);
			default: y = b_s1;
		endcase
		eq_sub = (cmd_s1 == CMD_SUB) && (a_s1 == b_s1);
		cancel = (negate_half(a_s1) == y) || (negate_half(y) == a_s1);

		ea     = a_s1[WORD_W-2 -: EXP_W];
		ey     = y[WORD_W-2 -: EXP_W];
		a_ge   = ea >= ey;
		diff   = a_ge ? (ea - ey) : (ey - ea);
		shamt  = (diff > EXP_W'(15)) ? SHAMT_W'(15) : diff[SHAMT_W-1:0];
		common = a_ge ? ea : ey;

		xv = signed_sig(a_s1);
		yv = signed_sig(y);
		xs = a_ge ? xv : half_t'($signed(xv) >>> shamt);
		ys = a_ge ? half_t'($signed(yv) >>> shamt) : yv;

		sum      = xs + ys;
		sum_sign = sum[WORD_W-1];
		mag16    = sum_sign ? half_t'(-sum) : sum;
		mag      = mag16[MAG_W-1:0];

		lz = '0;
		for (int i = 0; i <= MANT_W; i++) begin
			if (mag[i]) lz = LZ_W'(MANT_W - i);
		end
		norm = mag[MANT_W:0] << lz;

		if (mag[MAG_W-1]) begin
			// carry into bit 11: drop one bit and bump the exponent
			mant = mag[MANT_W:1];
			nexp = $signed({2'b00, common}) + 7'sd1;
		end else begin
			mant = norm[MANT_W-1:0];
			nexp = $signed({2'b00, common}) - $signed({3'b000, lz});
		end

		if (eq_sub || cancel || (mag == '0)) begin
			nxt_result = '0;
			nxt_err    = 1'b0;
		end else begin
			nxt_result = {sum_sign, nexp[EXP_W-1:0], mant};
			nxt_err    = nexp[NEXP_W-1:EXP_W] != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (operation.ready) valid_s1 <= operation.valid;
			if (!valid_s2 || outcome.ready) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1 <= operation.command;
			a_s1   <= operation.operand_a;
			b_s1   <= operation.operand_b;
		end
		if (move_s1) begin
			result_s2 <= nxt_result;
			err_s2    <= nxt_err;
		end
	end

	assign outcome.valid                = valid_s2;
	assign outcome.result               = result_s2;
	assign outcome.exponent_range_error = err_s2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!operation.ready |-> (valid_s1 && valid_s2 && !outcome.ready))
		else $error("input held back while a stage is free");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("first stage did not advance into an empty result stage");

	a_equal_sub_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (cmd_s1 == CMD_SUB) && (a_s1 == b_s1))
		|-> (nxt_result == '0 && !nxt_err))
		else $error("equal operands subtracted to non-zero");

	a_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !mag[MAG_W-1] && (mag != '0)) |-> norm[MANT_W])
		else $error("magnitude not normalised to its leading one");

endmodule

`default_nettype wire

>>> tb/half_float_add_sub_test.sv
`default_nettype none

module half_float_add_sub_test;
	import hfas_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic  command;
		half_t operand_a;
		half_t operand_b;
	} op_item_t;

	typedef struct packed {
		half_t result;
		logic  range_err;
	} sum_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hfas_op_if  op_ch ();
	hfas_res_if res_ch ();

	half_float_add_sub u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.operation (op_ch),
		.outcome   (res_ch)
	);

	op_item_t pending_ops[$];
	sum_t     due_sums[$];

	logic  drv_valid = 1'b0;
	logic  drv_cmd = CMD_ADD;
	half_t drv_a = '0;
	half_t drv_b = '0;
	logic  mon_ready = 1'b0;

	int gap_left = 0;
	int drv_quiet = 0;
	int stall_left = 0;
	int mon_quiet = 0;
	int items_sent = 0;
	int item_total = 0;
	int idle_cycles = 0;
	int mismatches = 0;

	assign op_ch.valid     = drv_valid;
	assign op_ch.command   = drv_cmd;
	assign op_ch.operand_a = drv_a;
	assign op_ch.operand_b = drv_b;
	assign res_ch.ready    = mon_ready;

	function automatic half_t flip_sign(input half_t x);
		flip_sign = (x == '0) ? x : (x ^ SIGN_MASK);
	endfunction

	function automatic half_t to_twos(input half_t x);
		half_t m;
		m = {5'b0, 1'b1, x[9:0]};
		to_twos = x[15] ? half_t'(-m) : m;
	endfunction

	function automatic sum_t half_sum(input logic cmd, input half_t a, input half_t b);
		sum_t  r;
		half_t y, xv, yv, mag;
		int    xe, ye, shift_by, common, lead;
		logic  sgn;
		r = '0;
		if (cmd == CMD_SUB) begin
			if (a == b)
				return r;
			y = flip_sign(b);
		end else begin
			y = b;
		end
		if (flip_sign(a) == y || flip_sign(y) == a)
			return r;
		xe = int'(a[14:10]);
		ye = int'(y[14:10]);
		xv = to_twos(a);
		yv = to_twos(y);
		// align the smaller exponent, saturating the distance at 15
		if (xe >= ye) begin
			common = xe;
			shift_by = (xe - ye > 15) ? 15 : xe - ye;
			yv = half_t'($signed(yv) >>> shift_by);
		end else begin
			common = ye;
			shift_by = (ye - xe > 15) ? 15 : ye - xe;
			xv = half_t'($signed(xv) >>> shift_by);
		end
		mag = xv + yv;
		sgn = mag[15];
		if (sgn)
			mag = -mag;
		lead = -1;
		for (int i = 15; i >= 0; i--) begin
			if (mag[i] && lead < 0)
				lead = i;
		end
		if (lead < 0)
			return r;
		if (lead > 10) begin
			mag = mag >> (lead - 10);
			common = common + (lead - 10);
		end else begin
			mag = mag << (10 - lead);
			common = common - (10 - lead);
		end
		r.range_err = (common < 0 || common > 31);
		r.result = {sgn, common[4:0], mag[9:0]};
		return r;
	endfunction

	// mostly short gaps, a few long ones, and now and then a quiet stretch
	function automatic int pick_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			quiet = $urandom_range(30, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic queue_op(input logic cmd, input half_t a, input half_t b);
		pending_ops.push_back(op_item_t'{cmd, a, b});
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic     take;
		int       g;
		op_item_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			take = drv_valid && op_ch.ready;
			if (take) begin
				due_sums.push_back(half_sum(drv_cmd, drv_a, drv_b));
				items_sent <= items_sent + 1;
			end
			// hold the item until its transfer
			if (!drv_valid || take) begin
				g = take ? pick_gap(drv_quiet) : gap_left;
				if (g > 0 || pending_ops.size() == 0) begin
					drv_valid <= 1'b0;
					gap_left <= (g > 0) ? g - 1 : 0;
				end else begin
					nxt = pending_ops.pop_front();
					drv_valid <= 1'b1;
					drv_cmd <= nxt.command;
					drv_a <= nxt.operand_a;
					drv_b <= nxt.operand_b;
					gap_left <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		sum_t want;
		int   g;
		if (!arst_n) begin
			mon_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_ch.valid && mon_ready) begin
				if (due_sums.size() == 0) begin
					$error("result transfer with nothing due: result=%h range_err=%b",
						res_ch.result, res_ch.exponent_range_error);
					mismatches++;
				end else begin
					want = due_sums.pop_front();
					if (res_ch.result !== want.result) begin
						$error("result: expected %h, got %h", want.result, res_ch.result);
						mismatches++;
					end
					if (res_ch.exponent_range_error !== want.range_err) begin
						$error("exponent_range_error: expected %b, got %b",
							want.range_err, res_ch.exponent_range_error);
						mismatches++;
					end
				end
			end
			g = stall_left;
			if (g == 0 && $urandom_range(0, 2) == 0)
				g = pick_gap(mon_quiet);
			if (g > 0) begin
				mon_ready <= 1'b0;
				stall_left <= g - 1;
			end else begin
				mon_ready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		half_t corner_vals[6];
		logic  cmd;
		half_t a, b;
		int    kind;

		corner_vals = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7C00, 16'hFC00};

		// zero words, signed zero, and cancellation either way round
		queue_op(CMD_ADD, 16'h0000, 16'h0000);
		queue_op(CMD_ADD, 16'h0000, 16'h8000);
		queue_op(CMD_SUB, 16'h0000, 16'h8000);
		queue_op(CMD_SUB, 16'h8000, 16'h0000);
		queue_op(CMD_SUB, 16'h1234, 16'h1234);
		queue_op(CMD_ADD, 16'h3C00, 16'hBC00);
		queue_op(CMD_ADD, 16'hBC00, 16'h3C00);
		// carry into bit 11
		queue_op(CMD_ADD, 16'h3C00, 16'h3C00);
		queue_op(CMD_SUB, 16'h3C00, 16'hBC00);
		// shared exponent
		queue_op(CMD_ADD, 16'h3E00, 16'h3D00);
		queue_op(CMD_SUB, 16'h3E00, 16'h3D00);
		// shift distance saturates, leaving zero or minus one
		queue_op(CMD_ADD, 16'h7C00, 16'h0000);
		queue_op(CMD_ADD, 16'h7C00, 16'h8000);
		// truncation makes the magnitudes match
		queue_op(CMD_ADD, 16'h0400, 16'h83FF);
		// exponent above 31, then other mixed cases
		queue_op(CMD_ADD, 16'h7C00, 16'h7C00);
		queue_op(CMD_ADD, 16'h7FFF, 16'h7FFF);
		queue_op(CMD_SUB, 16'h0001, 16'h0000);
		queue_op(CMD_ADD, 16'hFFFF, 16'hFFFF);
		queue_op(CMD_SUB, 16'hFFFF, 16'h7FFF);
		queue_op(CMD_ADD, 16'h5555, 16'hAAAA);
		queue_op(CMD_SUB, 16'hFFFF, 16'h0000);
		queue_op(CMD_ADD, 16'h4000, 16'h3FFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 9);
			cmd = 1'($urandom_range(0, 1));
			a = half_t'($urandom_range(0, 16'hFFFF));
			b = half_t'($urandom_range(0, 16'hFFFF));
			unique case (kind)
				3, 4: begin
					b[14:10] = a[14:10];
				end
				5: begin
					b[14:10] = a[14:10] + 5'($urandom_range(0, 4)) - 5'd2;
				end
				6: begin
					// near or exact cancellation
					b = (cmd == CMD_SUB) ? a : (a ^ SIGN_MASK);
					b[1:0] = b[1:0] ^ 2'($urandom_range(0, 3));
				end
				7: begin
					a = corner_vals[$urandom_range(0, 5)];
				end
				8: begin
					a = corner_vals[$urandom_range(0, 5)];
					b = corner_vals[$urandom_range(0, 5)];
				end
				9: begin
					a[14:10] = $urandom_range(0, 1) ? 5'($urandom_range(0, 1))
						: 5'($urandom_range(30, 31));
					b[14:10] = $urandom_range(0, 1) ? 5'($urandom_range(0, 1))
						: 5'($urandom_range(30, 31));
				end
				default: begin
				end
			endcase
			queue_op(cmd, a, b);
		end
		item_total = pending_ops.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (!(items_sent == item_total && due_sums.size() == 0)
				&& idle_cycles < IDLE_LIMIT)
			@(negedge clk);

		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (mismatches == 0 && due_sums.size() == 0)
				$display("Verification passed");
			else
				$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
